// ===== hdl/pts_pkg.sv =====
// Shared types, codes and table helpers for the priority task scheduler.
package pts_pkg;

  // Field widths and slot limits
  localparam int unsigned MAX_SLOTS = 8;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned PRIO_W    = 4;

  localparam logic [SLOT_W-1:0] IDLE_SLOT = 4'd8;

  // Request modes
  localparam logic [2:0] MODE_ACTIVATE  = 3'd0;
  localparam logic [2:0] MODE_TERMINATE = 3'd1;
  localparam logic [2:0] MODE_CHAIN     = 3'd2;
  localparam logic [2:0] MODE_SCHEDULE  = 3'd3;
  localparam logic [2:0] MODE_QUERY     = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_ID     = 2'd1;
  localparam logic [1:0] STAT_LIMIT     = 2'd2;
  localparam logic [1:0] STAT_CALLLEVEL = 2'd3;

  // Task states
  localparam logic [1:0] TS_SUSPENDED = 2'd0;
  localparam logic [1:0] TS_READY     = 2'd1;
  localparam logic [1:0] TS_RUNNING   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TASK_ID_TABLE = 2'd0;
  localparam logic [1:0] CFG_PRIORITY_TABLE = 2'd1;
  localparam logic [1:0] CFG_IDLE_PRIORITY = 2'd2;

  typedef struct packed {
    logic [2:0]      mode;
    logic [ID_W-1:0] task_id;
    logic            at_interrupt_level;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] active_slot;
    logic [ID_W-1:0]   active_id;
    logic [1:0]        requested_state;
    logic              switched;
  } rsp_t;

  typedef struct packed {
    logic [63:0]       id_tbl;
    logic [31:0]       prio_tbl;
    logic [PRIO_W-1:0] idle_prio;
  } cfg_t;

  // State memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_DISPATCH,
    PH_TERM,
    PH_ACT,
    PH_RSCH,
    PH_SWCUR,
    PH_SWBEST,
    PH_REQ_RD,
    PH_REQ_WT,
    PH_DONE
  } phase_t;

  function automatic logic [ID_W-1:0] slot_id(logic [63:0] tbl, logic [ADDR_W-1:0] s);
    return tbl[{s, 3'b000} +: ID_W];
  endfunction

  function automatic logic [PRIO_W-1:0] slot_prio(logic [31:0] tbl, logic [ADDR_W-1:0] s);
    return tbl[{s, 2'b00} +: PRIO_W];
  endfunction

endpackage

// ===== hdl/pts_state_mem.sv =====
// Task state memory: one write port, one registered read port, valid bits per entry.
module pts_state_mem #(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pts_pkg::mem_req_t mreq,
  output logic [1:0]        rdata
);
  import pts_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [1:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [1:0]       rd_r;
  logic             rd_vld_r;

  // Write and read the state array
  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem_q[mreq.waddr[AW-1:0]] <= mreq.wdata;
    end
    rd_r <= mem_q[mreq.raddr[AW-1:0]];
  end

  // Track written entries; unwritten entries read as suspended
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mreq.we) begin
        vld_r[mreq.waddr[AW-1:0]] <= 1'b1;
      end
      rd_vld_r <= vld_r[mreq.raddr[AW-1:0]];
    end
  end

  assign rdata = rd_vld_r ? rd_r : TS_SUSPENDED;

endmodule

// ===== hdl/pts_ctrl.sv =====
// Request sequencer: scans the state memory for activate and reschedule, and reads the requested task's state.
module pts_ctrl #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pts_pkg::req_t     in_req,
  output logic              in_stall,
  input  pts_pkg::cfg_t     cfg,
  output pts_pkg::mem_req_t mreq,
  input  logic [1:0]        rdata,
  input  logic              out_busy,
  output logic              done,
  output pts_pkg::rsp_t     rsp
);
  import pts_pkg::*;

  localparam logic [SLOT_W-1:0] N_SLOTS = SLOT_W'(TASK_COUNT);

  phase_t state_r, state_nxt;

  logic [2:0]        mode_r, mode_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              irq_r, irq_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [1:0]        cur_st_r, cur_st_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [1:0]        idle_st_r, idle_st_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              sw_r, sw_nxt;
  logic [1:0]        req_st_r, req_st_nxt;

  logic [MAX_SLOTS-1:0] match;
  logic                 any_match;
  logic [ADDR_W-1:0]    first_idx;
  logic                 issue;
  logic                 last_eval;
  logic                 act_hit;
  logic [SLOT_W-1:0]    best_c;
  logic [PRIO_W-1:0]    best_prio_c;
  logic [1:0]           cur_st_c;
  logic [PRIO_W-1:0]    cur_prio;
  logic                 do_switch;

  // Match the requested ID against the configured slots
  always_comb begin
    match     = '0;
    first_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      match[i] = (i < TASK_COUNT) && (slot_id(cfg.id_tbl, ADDR_W'(i)) == id_r);
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = ADDR_W'(i);
      end
    end
  end
  assign any_match = |match;

  // Scan pipeline status
  assign issue     = (state_r == PH_ACT || state_r == PH_RSCH) && (cnt_r < N_SLOTS);
  assign last_eval = rd_vld_r && (rd_idx_r == N_SLOTS - SLOT_W'(1));
  assign act_hit   = (state_r == PH_ACT) && rd_vld_r && match[rd_idx_r[ADDR_W-1:0]]
                     && (rdata == TS_SUSPENDED);

  // Fold one slot into the best ready candidate
  always_comb begin
    best_c      = best_r;
    best_prio_c = best_prio_r;
    cur_st_c    = cur_st_r;
    if (rd_vld_r) begin
      if (rdata == TS_READY
          && slot_prio(cfg.prio_tbl, rd_idx_r[ADDR_W-1:0]) > best_prio_r) begin
        best_c      = rd_idx_r;
        best_prio_c = slot_prio(cfg.prio_tbl, rd_idx_r[ADDR_W-1:0]);
      end
      if (rd_idx_r == cur_slot_r) begin
        cur_st_c = rdata;
      end
    end
  end

  assign cur_prio  = (cur_slot_r == IDLE_SLOT) ? cfg.idle_prio
                                               : slot_prio(cfg.prio_tbl, cur_slot_r[ADDR_W-1:0]);
  assign do_switch = (cur_st_c != TS_RUNNING) || (best_prio_c > cur_prio);

  // Next phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_IDLE: begin
        if (in_valid) begin
          state_nxt = PH_DISPATCH;
        end
      end
      PH_DISPATCH: begin
        unique case (mode_r)
          MODE_ACTIVATE:  state_nxt = PH_ACT;
          MODE_TERMINATE: state_nxt = PH_TERM;
          MODE_CHAIN:     state_nxt = PH_TERM;
          MODE_SCHEDULE:  state_nxt = irq_r ? PH_REQ_RD : PH_RSCH;
          default:        state_nxt = PH_REQ_RD;
        endcase
      end
      PH_TERM: begin
        if (mode_r == MODE_CHAIN) begin
          state_nxt = PH_ACT;
        end else begin
          state_nxt = irq_r ? PH_REQ_RD : PH_RSCH;
        end
      end
      PH_ACT: begin
        if (act_hit) begin
          state_nxt = irq_r ? PH_REQ_RD : PH_RSCH;
        end else if (last_eval) begin
          state_nxt = PH_REQ_RD;
        end
      end
      PH_RSCH: begin
        if (last_eval) begin
          state_nxt = do_switch ? PH_SWCUR : PH_REQ_RD;
        end
      end
      PH_SWCUR:  state_nxt = PH_SWBEST;
      PH_SWBEST: state_nxt = PH_REQ_RD;
      PH_REQ_RD: state_nxt = PH_REQ_WT;
      PH_REQ_WT: state_nxt = PH_DONE;
      PH_DONE: begin
        if (!out_busy) begin
          state_nxt = PH_IDLE;
        end
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  // Memory access, handshake and completion
  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = cur_slot_r[ADDR_W-1:0];
    mreq.wdata = TS_SUSPENDED;
    mreq.raddr = cnt_r[ADDR_W-1:0];
    unique case (state_r)
      PH_TERM: begin
        mreq.we = (cur_slot_r != IDLE_SLOT);
      end
      PH_ACT: begin
        mreq.we    = act_hit;
        mreq.waddr = rd_idx_r[ADDR_W-1:0];
        mreq.wdata = TS_READY;
      end
      PH_SWCUR: begin
        mreq.we    = (cur_st_r == TS_RUNNING) && (cur_slot_r != IDLE_SLOT);
        mreq.wdata = TS_READY;
      end
      PH_SWBEST: begin
        mreq.we    = (best_r != IDLE_SLOT);
        mreq.waddr = best_r[ADDR_W-1:0];
        mreq.wdata = TS_RUNNING;
      end
      PH_REQ_RD: begin
        mreq.raddr = first_idx;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state_r != PH_IDLE);
  assign done     = (state_r == PH_DONE) && !out_busy;

  // Datapath updates
  always_comb begin
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    irq_nxt       = irq_r;
    status_nxt    = status_r;
    sw_nxt        = sw_r;
    req_st_nxt    = req_st_r;
    idle_st_nxt   = idle_st_r;
    cur_slot_nxt  = cur_slot_r;
    best_nxt      = best_r;
    best_prio_nxt = best_prio_r;
    cur_st_nxt    = cur_st_r;

    unique case (state_r)
      PH_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_req.mode;
          id_nxt     = in_req.task_id;
          irq_nxt    = in_req.at_interrupt_level;
          status_nxt = STAT_OK;
          sw_nxt     = 1'b0;
        end
      end
      PH_DISPATCH: begin
        if (mode_r == MODE_SCHEDULE && irq_r) begin
          status_nxt = STAT_CALLLEVEL;
        end else if (mode_r == MODE_QUERY) begin
          status_nxt = any_match ? STAT_OK : STAT_NO_ID;
        end
      end
      PH_TERM: begin
        if (cur_slot_r == IDLE_SLOT) begin
          idle_st_nxt = TS_SUSPENDED;
        end
        if (mode_r != MODE_CHAIN && irq_r) begin
          status_nxt = STAT_CALLLEVEL;
        end
      end
      PH_ACT: begin
        if (act_hit && irq_r) begin
          status_nxt = STAT_CALLLEVEL;
        end else if (!act_hit && last_eval) begin
          status_nxt = any_match ? STAT_LIMIT : STAT_NO_ID;
        end
      end
      PH_SWCUR: begin
        if (cur_st_r == TS_RUNNING && cur_slot_r == IDLE_SLOT) begin
          idle_st_nxt = TS_READY;
        end
      end
      PH_SWBEST: begin
        if (best_r == IDLE_SLOT) begin
          idle_st_nxt = TS_RUNNING;
        end
        cur_slot_nxt = best_r;
        sw_nxt       = 1'b1;
      end
      PH_REQ_WT: begin
        req_st_nxt = any_match ? rdata : TS_SUSPENDED;
      end
      default: begin
      end
    endcase

    // Seed the candidate search before a reschedule, hold it through the switch
    if (state_r == PH_RSCH) begin
      best_nxt      = best_c;
      best_prio_nxt = best_prio_c;
      cur_st_nxt    = cur_st_c;
    end else if (state_r != PH_SWCUR && state_r != PH_SWBEST) begin
      best_nxt      = IDLE_SLOT;
      best_prio_nxt = cfg.idle_prio;
      cur_st_nxt    = idle_st_nxt;
    end
  end

  // Scan counter and read pipeline
  always_comb begin
    cnt_nxt    = issue ? cnt_r + SLOT_W'(1) : cnt_r;
    rd_vld_nxt = issue;
    rd_idx_nxt = cnt_r;
    if (state_nxt != state_r) begin
      cnt_nxt    = '0;
      rd_vld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= PH_IDLE;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      cur_slot_r <= IDLE_SLOT;
      idle_st_r  <= TS_RUNNING;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      cur_slot_r <= cur_slot_nxt;
      idle_st_r  <= idle_st_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    id_r        <= id_nxt;
    irq_r       <= irq_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_r      <= best_nxt;
    best_prio_r <= best_prio_nxt;
    cur_st_r    <= cur_st_nxt;
    status_r    <= status_nxt;
    sw_r        <= sw_nxt;
    req_st_r    <= req_st_nxt;
  end

  // Assemble the response
  always_comb begin
    rsp.status          = status_r;
    rsp.active_slot     = cur_slot_r;
    rsp.active_id       = (cur_slot_r == IDLE_SLOT) ? '0
                                                    : slot_id(cfg.id_tbl, cur_slot_r[ADDR_W-1:0]);
    rsp.requested_state = req_st_r;
    rsp.switched        = sw_r;
  end

endmodule

// ===== hdl/priority_task_scheduler.sv =====
// Priority task scheduler: a task-state table with priority preemption.
//
// Requests arrive on the in_ channel (valid/stall); one response per request
// leaves on the out_ channel (valid/stall). A request is taken when in_valid
// is high and in_stall is low. Tables are loaded through the cfg_ write port
// (index 0 task IDs, 1 priorities, 2 idle priority) while no request is open.
//
// Task states live in a small synchronous memory with a registered read. Each
// request is served by a sequencer that reads one slot per cycle while it
// scans: the reschedule scan walks all slots through the memory port, and the
// activate scan walks them until it finds a matching suspended slot.
// Only one request is open at a time; the next is taken once the response is
// in the output register, which holds it until the receiver takes it.
//
// Reset (rst_n low, synchronous) marks all slots suspended, makes the idle
// task running and active, restores the default tables and empties the
// output register. While out_stall is high the finished response waits and a
// further finished request waits behind it.
module priority_task_scheduler #(
  parameter int unsigned TASK_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pts_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pts_pkg::rsp_t out_data,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_idx,
  input  logic [63:0]   cfg_wdata
);
  import pts_pkg::*;

  cfg_t     cfg_r;
  mem_req_t mreq;
  logic [1:0] rdata;
  logic     done;
  rsp_t     rsp;
  logic     out_valid_r;
  rsp_t     out_data_r;
  logic     out_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_tbl    <= 64'h0706_0504_0302_0100;
      cfg_r.prio_tbl  <= '0;
      cfg_r.idle_prio <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_TASK_ID_TABLE:  cfg_r.id_tbl    <= cfg_wdata;
        CFG_PRIORITY_TABLE: cfg_r.prio_tbl  <= cfg_wdata[31:0];
        CFG_IDLE_PRIORITY:  cfg_r.idle_prio <= cfg_wdata[PRIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pts_state_mem #(
    .DEPTH(TASK_COUNT)
  ) u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .mreq (mreq),
    .rdata(rdata)
  );

  pts_ctrl #(
    .TASK_COUNT(TASK_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_req  (in_data),
    .in_stall(in_stall),
    .cfg     (cfg_r),
    .mreq    (mreq),
    .rdata   (rdata),
    .out_busy(out_busy),
    .done    (done),
    .rsp     (rsp)
  );

  // Hold the response until the receiver takes it
  assign out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An accepted request keeps the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but sequencer not busy");

  // The active slot is the idle task or a present slot
  a_active_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.active_slot == IDLE_SLOT
                   || out_data.active_slot < SLOT_W'(TASK_COUNT)))
    else $error("active slot out of range");

  // The idle task reports ID zero
  a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.active_slot == IDLE_SLOT |-> out_data.active_id == '0)
    else $error("idle task with nonzero ID");

  // A context switch only comes with ok status
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.switched |-> out_data.status == STAT_OK)
    else $error("switch reported with error status");
`endif

endmodule
